FILE: hdl/multidim_array_access_top_defines.svh
// Assertion macros used by the checker of the array access block.
`ifndef MULTIDIM_ARRAY_ACCESS_TOP_DEFINES_SVH
`define MULTIDIM_ARRAY_ACCESS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define MDAA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define MDAA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/mdaa_pkg.sv
// Shared types and constants of the multidimensional array access block.
`timescale 1ns / 1ps
`default_nettype none
package mdaa_pkg;

	// Access kinds.
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_INDEX  = 2'd1;
	localparam logic [1:0] STAT_OFFSET = 2'd2;

	// Configuration register map.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_3  = 3'd4;

	localparam int EXT_W   = 13;
	localparam int IDX_W   = 12;
	localparam int WDATA_W = 32;

	// One access beat.
	typedef struct packed {
		logic               mode;
		logic [IDX_W-1:0]   index_0;
		logic [IDX_W-1:0]   index_1;
		logic [IDX_W-1:0]   index_2;
		logic [IDX_W-1:0]   index_3;
		logic [WDATA_W-1:0] write_data;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic [WDATA_W-1:0] read_data;
		logic [1:0]         status;
	} rsp_t;

	// Classified access passed from the front to the back, less its address.
	typedef struct packed {
		logic               mode;
		logic [1:0]         status;
		logic [WDATA_W-1:0] write_data;
	} job_t;

endpackage
`default_nettype wire

FILE: hdl/multidim_array_access_top.sv
// Top level of the row-major multidimensional array access block.
//
// A beat on cmd is taken at a clock edge where start is high and busy is
// low. It carries the access kind, four indices (index_0 most significant)
// and the value to store on a write. Each beat gives exactly one result on
// result, shown for one cycle while done is high; the receiver must take it.
// Configuration is written through cfg_we, cfg_idx and cfg_data: index 0 is
// the dimension count, indices 1 to 4 the extents; other indices are ignored.
// The front end checks the indices and forms the offset by Horner's rule,
// one multiply-add for each dimension after the first, then hands the
// access to a short queue. The back end reads or writes the element
// store, one access a cycle. Busy stays high until the access enters the
// queue, so a new beat is taken only once the last has been handed on.
// Reset sets one dimension and all extents to one and empties the
// pipeline; the element store holds nothing meaningful until written.
`timescale 1ns / 1ps
`default_nettype none
module multidim_array_access_top #(
	parameter int MAX_DIMS    = 4,
	parameter int STORE_DEPTH = 4096,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire mdaa_pkg::cmd_t                  cmd,
	output logic                                 busy,
	output logic                                 done,
	output mdaa_pkg::rsp_t                       result,
	input  wire logic                            cfg_we,
	input  wire logic [mdaa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [mdaa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mdaa_pkg::*;

	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int JOB_W  = $bits(job_t);
	localparam int QW     = JOB_W + ADDR_W;

	logic              push_valid;
	job_t              push_job;
	logic [ADDR_W-1:0] push_addr;
	logic              q_full;
	logic              q_valid;
	logic              q_pop;
	logic [QW-1:0]     q_data;
	job_t              q_job;
	logic [ADDR_W-1:0] q_addr;

	mdaa_front #(
		.MAX_DIMS   (MAX_DIMS),
		.STORE_DEPTH(STORE_DEPTH),
		.ADDR_W     (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.push_valid(push_valid),
		.push_job  (push_job),
		.push_addr (push_addr),
		.q_full    (q_full)
	);

	mdaa_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_data({push_job, push_addr}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.not_empty(q_valid)
	);

	assign q_job  = q_data[QW-1:ADDR_W];
	assign q_addr = q_data[ADDR_W-1:0];

	mdaa_back #(
		.STORE_DEPTH(STORE_DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_job  (q_job),
		.q_addr (q_addr),
		.q_pop  (q_pop),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

FILE: hdl/mdaa_front.sv
// Front end: configuration registers, index checks and row-major offset forming.
`timescale 1ns / 1ps
`default_nettype none
module mdaa_front #(
	parameter int MAX_DIMS    = 4,
	parameter int STORE_DEPTH = 4096,
	parameter int ADDR_W      = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire mdaa_pkg::cmd_t                  cmd,
	output logic                                 busy,
	input  wire logic                            cfg_we,
	input  wire logic [mdaa_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [mdaa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                 push_valid,
	output mdaa_pkg::job_t                       push_job,
	output logic [ADDR_W-1:0]                    push_addr,
	input  wire logic                            q_full
);
	import mdaa_pkg::*;

	localparam int PW = ADDR_W + EXT_W + 1;
	localparam logic S_IDLE = 1'b0;
	localparam logic S_CALC = 1'b1;

	logic               state_q;
	logic [2:0]         dim_count_q;
	logic [EXT_W-1:0]   ext_q [4];
	logic [IDX_W-1:0]   idx_q [4];
	logic [2:0]         step_q;
	logic [ADDR_W-1:0]  acc_q;
	logic               ovf_q;
	logic               err_q;
	logic               mode_q;
	logic [WDATA_W-1:0] wdata_q;

	logic [2:0]  dims;
	logic        accept;
	logic        idx_err;
	logic [PW-1:0] horner;
	logic        calc_more;

	// Dimension count clamped to the supported range.
	always_comb begin
		if (dim_count_q == 3'd0) begin
			dims = 3'd1;
		end else if (dim_count_q > 3'(MAX_DIMS)) begin
			dims = 3'(MAX_DIMS);
		end else begin
			dims = dim_count_q;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// An index of a used dimension at or beyond its extent is rejected.
	always_comb begin
		idx_err = 1'b0;
		if ({1'b0, cmd.index_0} >= ext_q[0]) begin
			idx_err = 1'b1;
		end
		if (dims > 3'd1 && {1'b0, cmd.index_1} >= ext_q[1]) begin
			idx_err = 1'b1;
		end
		if (dims > 3'd2 && {1'b0, cmd.index_2} >= ext_q[2]) begin
			idx_err = 1'b1;
		end
		if (dims > 3'd3 && {1'b0, cmd.index_3} >= ext_q[3]) begin
			idx_err = 1'b1;
		end
	end

	// One Horner step: offset so far times the next extent plus the next index.
	assign horner = PW'(acc_q) * PW'(ext_q[step_q[1:0]]) + PW'(idx_q[step_q[1:0]]);
	assign calc_more = (step_q < dims);

	// Configuration writes; indexes past the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= 3'd1;
			ext_q[0]    <= EXT_W'(1);
			ext_q[1]    <= EXT_W'(1);
			ext_q[2]    <= EXT_W'(1);
			ext_q[3]    <= EXT_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DIM_COUNT: dim_count_q <= cfg_data[2:0];
				REG_EXTENT_0:  ext_q[0] <= cfg_data;
				REG_EXTENT_1:  ext_q[1] <= cfg_data;
				REG_EXTENT_2:  ext_q[2] <= cfg_data;
				REG_EXTENT_3:  ext_q[3] <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Sequencer: capture on accept, then one offset step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= 3'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CALC;
						step_q  <= 3'd1;
					end
				end
				S_CALC: begin
					if (calc_more) begin
						step_q <= step_q + 3'd1;
					end else if (!q_full) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload and running offset.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q[0] <= cmd.index_0;
			idx_q[1] <= cmd.index_1;
			idx_q[2] <= cmd.index_2;
			idx_q[3] <= cmd.index_3;
			mode_q   <= cmd.mode;
			wdata_q  <= cmd.write_data;
			err_q    <= idx_err;
			acc_q    <= ADDR_W'(cmd.index_0);
			ovf_q    <= (32'(cmd.index_0) >= 32'(STORE_DEPTH));
		end else if (state_q == S_CALC && calc_more) begin
			acc_q <= horner[ADDR_W-1:0];
			ovf_q <= ovf_q || (horner >= PW'(STORE_DEPTH));
		end
	end

	// Hand the classified access to the queue.
	assign push_valid          = (state_q == S_CALC) && !calc_more && !q_full;
	assign push_job.mode       = mode_q;
	assign push_job.write_data = wdata_q;
	assign push_job.status     = err_q ? STAT_INDEX : (ovf_q ? STAT_OFFSET : STAT_OK);
	assign push_addr           = acc_q;

endmodule
`default_nettype wire

FILE: hdl/mdaa_queue.sv
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module mdaa_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              not_empty
);
	import mdaa_pkg::*;

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mdaa_back.sv
// Back end: element store access and result register.
`timescale 1ns / 1ps
`default_nettype none
module mdaa_back #(
	parameter int STORE_DEPTH = 4096,
	parameter int DATA_WIDTH  = 32,
	parameter int ADDR_W      = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire mdaa_pkg::job_t    q_job,
	input  wire logic [ADDR_W-1:0] q_addr,
	output logic                   q_pop,
	output logic                   done,
	output mdaa_pkg::rsp_t         result
);
	import mdaa_pkg::*;

	logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
	logic [DATA_WIDTH-1:0] rd_s1;
	logic                  valid_s1;
	logic                  rd_ok_s1;
	logic [1:0]            status_s1;
	logic                  do_write;
	logic [63:0]           wdata_wide;
	logic [63:0]           rdata_wide;

	// The back end never stalls, so any queued beat is taken at once.
	assign q_pop      = q_valid;
	assign do_write   = q_valid && (q_job.status == STAT_OK) && (q_job.mode == MODE_WRITE);
	assign wdata_wide = 64'(q_job.write_data);
	assign rdata_wide = 64'(rd_s1);

	// Element store with registered read.
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[q_addr] <= wdata_wide[DATA_WIDTH-1:0];
		end
		if (q_valid) begin
			rd_s1 <= mem[q_addr];
		end
	end

	// Result control stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid) begin
			status_s1 <= q_job.status;
			rd_ok_s1  <= (q_job.status == STAT_OK) && (q_job.mode == MODE_READ);
		end
	end

	// Only a successful read returns data.
	assign done             = valid_s1;
	assign result.status    = status_s1;
	assign result.read_data = rd_ok_s1 ? rdata_wide[WDATA_W-1:0] : '0;

endmodule
`default_nettype wire

FILE: hdl/mdaa_checker.sv
// Port-level checker for the array access block and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "multidim_array_access_top_defines.svh"
module mdaa_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire logic           done,
	input wire mdaa_pkg::rsp_t result
);
	import mdaa_pkg::*;

	// An accepted beat keeps the block busy in the following cycle.
	`MDAA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after accept")

	// The end of front-end work is followed by its result in the next cycle.
	`MDAA_ASSERT_NEXT(a_done_after_release, $fell(busy), done, "missing result after release")

	// A result is never followed directly by another result.
	`MDAA_ASSERT_NEXT(a_done_spaced, done, !done, "results on adjacent cycles")

	// A failed access returns zero data.
	`MDAA_ASSERT_NOW(a_err_zero, done && (result.status != STAT_OK), result.read_data == '0,
		"non-zero data with error status")

endmodule

bind multidim_array_access_top mdaa_checker u_mdaa_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
`default_nettype wire
